### rtl/cas_pkg.sv
// Shared types and constants of the cave automaton step block.
`default_nettype none

package cas_pkg;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_GRID_WIDTH  = 2'd0;
  localparam cfg_index_t REG_GRID_HEIGHT = 2'd1;
  localparam cfg_index_t REG_SURVIVE_MIN = 2'd2;
  localparam cfg_index_t REG_BIRTH_MIN   = 2'd3;

  typedef logic [7:0] cfg_data_t;
  typedef logic [7:0] geom_t;
  typedef logic [3:0] thresh_t;

  // Register reset values
  localparam geom_t   GRID_WIDTH_RESET  = 8'd128;
  localparam geom_t   GRID_HEIGHT_RESET = 8'd128;
  localparam thresh_t SURVIVE_RESET     = 4'd4;
  localparam thresh_t BIRTH_RESET       = 4'd5;

  // Geometry floor
  localparam geom_t MIN_WIDTH  = 8'd3;
  localparam geom_t MIN_HEIGHT = 8'd1;

  // Input item modes
  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

endpackage : cas_pkg

`default_nettype wire

### rtl/cas_if.sv
// Valid/ready channel interfaces: configuration writes, input cells, results.
`default_nettype none

interface cas_cfg_if;
  logic                valid;
  logic                ready;
  cas_pkg::cfg_index_t index;
  cas_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : cas_cfg_if

interface cas_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic cell_req;

  modport source (output valid, output mode, output cell_req, input ready);
  modport sink   (input valid, input mode, input cell_req, output ready);
endinterface : cas_in_if

interface cas_out_if;
  logic valid;
  logic ready;
  logic next_cell;
  logic frame_last;

  modport source (output valid, output next_cell, output frame_last, input ready);
  modport sink   (input valid, input next_cell, input frame_last, output ready);
endinterface : cas_out_if

`default_nettype wire

### rtl/cave_automaton_step.sv
// Cave automaton step: one generation of a 4/5-rule cave grid over a raster stream.
//
// Channels: item carries one request per grid cell in raster order (mode = cell)
// or a flush tick (mode = flush); result carries next_cell and frame_last; cfg
// writes grid_width, grid_height, survive_min and birth_min by index, always ready.
// The result for cell k is released by request k+width+1; after the last cell,
// width+1 flush requests drain the remaining results. A flush with nothing pending,
// or while cells are still expected, is taken and dropped.
// Throughput: one request per cycle while result is not stalled. The edge that takes
// a request does the line store read (two row stores indexed by column, each read once
// per request and written once per cell request of the grid) into stage one; when the
// pipeline next moves, the neighbor count and rule go into the result register.
// Geometry is latched from the registers on the first cell of each frame.
// Reset clears the position counters and both pipeline valids and reloads the
// register defaults; row store contents are not cleared. When result is
// stalled, the pipeline holds and item.ready drops in the same cycle.
`default_nettype none

module cave_automaton_step #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic       clk,
  input  logic       rst,
  cas_cfg_if.sink    cfg,
  cas_in_if.sink     item,
  cas_out_if.source  result
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int W_RESET = (128 > MAX_WIDTH) ? MAX_WIDTH : 128;
  localparam int H_RESET = (128 > MAX_HEIGHT) ? MAX_HEIGHT : 128;

  typedef struct packed {
    logic valid;
    logic store;
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } stage_ctl_t;

  // Configuration registers
  cas_pkg::geom_t   grid_width;
  cas_pkg::geom_t   grid_height;
  cas_pkg::thresh_t survive_min;
  cas_pkg::thresh_t birth_min;

  // Frame geometry and input position
  logic [FW-1:0] frame_w;
  logic [HW-1:0] frame_h;
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_row;

  // Row stores and their registered read data
  logic          mem_mid [MAX_WIDTH];
  logic          mem_up  [MAX_WIDTH];
  logic          rd_mid;
  logic          rd_up;

  // Stage one and the window columns {top, mid, bottom}
  stage_ctl_t    s1;
  logic [CW-1:0] s1_col;
  logic          s1_cell;
  logic [2:0]    prev1;
  logic [2:0]    prev2;

  // Result register
  logic          out_valid;
  logic          out_next;
  logic          out_last;

  // Decode of the incoming request
  logic          move;
  logic          acc;
  logic          pos0;
  logic [FW-1:0] clamp_w;
  logic [HW-1:0] clamp_h;
  logic [FW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          adv_item;
  logic          store;
  logic          emit;
  logic [RW-1:0] em_row;
  logic [CW-1:0] em_col;
  logic          last_col;
  logic          last;
  logic          col_wrap;
  stage_ctl_t    s1_next;

  // Neighborhood and rule
  logic [2:0]    cur;
  logic [2:0]    lft_m;
  logic [2:0]    rgt_m;
  logic          ctr_top;
  logic          ctr_bot;
  logic [3:0]    count;
  logic          rule_out;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= cas_pkg::GRID_WIDTH_RESET;
      grid_height <= cas_pkg::GRID_HEIGHT_RESET;
      survive_min <= cas_pkg::SURVIVE_RESET;
      birth_min   <= cas_pkg::BIRTH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        cas_pkg::REG_GRID_WIDTH:  grid_width  <= cfg.data;
        cas_pkg::REG_GRID_HEIGHT: grid_height <= cfg.data;
        cas_pkg::REG_SURVIVE_MIN: survive_min <= cfg.data[3:0];
        cas_pkg::REG_BIRTH_MIN:   birth_min   <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the result register is free or being taken
  assign move       = !out_valid || result.ready;
  assign item.ready = move;
  assign acc        = item.valid && move;

  // Geometry clamp, applied on the first cell of a frame
  always_comb begin
    if (grid_width < cas_pkg::MIN_WIDTH) begin
      clamp_w = FW'(cas_pkg::MIN_WIDTH);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      clamp_w = FW'(MAX_WIDTH);
    end else begin
      clamp_w = FW'(grid_width);
    end
    if (grid_height < cas_pkg::MIN_HEIGHT) begin
      clamp_h = HW'(cas_pkg::MIN_HEIGHT);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      clamp_h = HW'(MAX_HEIGHT);
    end else begin
      clamp_h = HW'(grid_height);
    end
  end

  assign pos0  = (in_row == '0) && (in_col == '0);
  assign eff_w = pos0 ? clamp_w : frame_w;
  assign eff_h = pos0 ? clamp_h : frame_h;

  // Classify the request and locate the cell whose result it releases
  always_comb begin
    store    = (in_row < RW'(eff_h));
    adv_item = (item.mode == cas_pkg::MODE_CELL) || !store;
    emit     = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (in_col != '0));
    if (in_col != '0) begin
      em_row = in_row - RW'(1);
      em_col = in_col - CW'(1);
    end else begin
      em_row = in_row - RW'(2);
      em_col = CW'(eff_w - FW'(1));
    end
    last_col = (FW'(em_col) == eff_w - FW'(1));
    last     = emit && last_col && (em_row == RW'(eff_h) - RW'(1));
    col_wrap = (FW'(in_col) == eff_w - FW'(1));

    s1_next.valid    = acc && adv_item;
    s1_next.store    = store;
    s1_next.emit     = emit;
    s1_next.last     = last;
    s1_next.top_ok   = (em_row != '0);
    s1_next.bot_ok   = ((em_row + RW'(1)) < RW'(eff_h));
    s1_next.left_ok  = (em_col != '0);
    s1_next.right_ok = !last_col;
  end

  // Position counters and latched geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      frame_w <= FW'(W_RESET);
      frame_h <= HW'(H_RESET);
    end else if (acc && adv_item) begin
      if (pos0) begin
        frame_w <= clamp_w;
        frame_h <= clamp_h;
      end
      if (last) begin
        in_col <= '0;
        in_row <= '0;
      end else if (col_wrap) begin
        in_col <= '0;
        in_row <= in_row + RW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  // Row stores: middle keeps the previous row, upper the one before it
  always_ff @(posedge clk) begin
    if (acc && adv_item) begin
      rd_mid <= mem_mid[in_col];
      rd_up  <= mem_up[in_col];
      if (store) begin
        mem_mid[in_col] <= item.cell_req;
      end
    end
    if (s1.valid && s1.store && move) begin
      mem_up[s1_col] <= rd_mid;
    end
  end

  // Stage one control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (move) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && adv_item) begin
      s1_col  <= in_col;
      s1_cell <= item.cell_req;
    end
  end

  // Window columns shift once per advancing request
  assign cur = {rd_up, rd_mid, s1_cell};

  always_ff @(posedge clk) begin
    if (s1.valid && move) begin
      prev2 <= prev1;
      prev1 <= cur;
    end
  end

  // Off-grid neighbors read as filled
  assign lft_m   = {3{!s1.left_ok}}  | {!s1.top_ok | prev2[2], prev2[1], !s1.bot_ok | prev2[0]};
  assign rgt_m   = {3{!s1.right_ok}} | {!s1.top_ok | cur[2],   cur[1],   !s1.bot_ok | cur[0]};
  assign ctr_top = !s1.top_ok | prev1[2];
  assign ctr_bot = !s1.bot_ok | prev1[0];
  assign count   = 4'($countones({lft_m, rgt_m, ctr_top, ctr_bot}));
  assign rule_out = prev1[1] ? (count >= survive_min) : (count >= birth_min);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= s1.valid && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (move && s1.valid && s1.emit) begin
      out_next <= rule_out;
      out_last <= s1.last;
    end
  end

  assign result.valid      = out_valid;
  assign result.next_cell  = out_next;
  assign result.frame_last = out_last;

endmodule : cave_automaton_step

`default_nettype wire

### verif/cave_step_checker.sv
// Result checker for the cave automaton step: tracks registers and requests, predicts, compares.
module cave_step_checker #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic clk,
  input  logic rst,
  cas_cfg_if   cfg_bus,
  cas_in_if    in_bus,
  cas_out_if   out_bus,
  input  logic stream_done,
  output int   pending_results,
  output int   fail_count,
  output int   results_checked,
  output int   frames_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Two rows plus a few cells of history cover every neighbor of a released cell
  localparam int HIST_DEPTH = 2 * MAX_WIDTH + 4;
  localparam int MAX_SHOWN  = 20;

  typedef struct packed {
    logic next_cell;
    logic frame_last;
  } cell_result_t;

  cell_result_t expected_cells[$];

  // Register copies
  cas_pkg::geom_t   width_reg, height_reg;
  cas_pkg::thresh_t survive_reg, birth_reg;

  // Frame state
  logic        hist_cells[HIST_DEPTH];
  int unsigned frame_w, frame_h, stream_pos;
  bit          tail_flagged;

  task automatic report_mismatch(string what);
    if (fail_count < MAX_SHOWN) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Cells off the grid read as walls
  function automatic logic wall_at(int r, int c);
    if (r < 0 || c < 0 || r >= int'(frame_h) || c >= int'(frame_w)) return 1'b1;
    return hist_cells[(r * int'(frame_w) + c) % HIST_DEPTH];
  endfunction

  // Neighbor count and survive/birth rule for cell k of the frame
  function automatic cell_result_t smooth_cell(int unsigned k);
    int          r, c, dr, dc;
    int unsigned walls;
    logic        centre;
    cell_result_t res;
    r     = int'(k / frame_w);
    c     = int'(k % frame_w);
    walls = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) walls += wall_at(r + dr, c + dc);
      end
    end
    centre = wall_at(r, c);
    res.next_cell  = centre ? (walls >= survive_reg) : (walls >= birth_reg);
    res.frame_last = (k + 1 == frame_w * frame_h);
    return res;
  endfunction

  // One accepted request: store the cell, release the cell up-left of it
  function automatic void generation_step(logic md, logic cv);
    int unsigned  total;
    cell_result_t res;
    if (stream_pos == 0) begin
      // idle flush is dropped; a cell opens a frame and latches geometry
      if (md == cas_pkg::MODE_FLUSH) return;
      frame_w = clamp_dim(width_reg, cas_pkg::MIN_WIDTH, MAX_WIDTH);
      frame_h = clamp_dim(height_reg, cas_pkg::MIN_HEIGHT, MAX_HEIGHT);
    end
    total = frame_w * frame_h;
    if (stream_pos < total) begin
      // flush while cells are still due is dropped
      if (md == cas_pkg::MODE_FLUSH) return;
      hist_cells[stream_pos % HIST_DEPTH] = cv;
    end
    if (stream_pos >= frame_w + 1) begin
      res = smooth_cell(stream_pos - frame_w - 1);
      expected_cells.push_back(res);
      if (res.frame_last) begin
        stream_pos = 0;
        return;
      end
    end
    stream_pos++;
  endfunction

  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      width_reg    = cas_pkg::GRID_WIDTH_RESET;
      height_reg   = cas_pkg::GRID_HEIGHT_RESET;
      survive_reg  = cas_pkg::SURVIVE_RESET;
      birth_reg    = cas_pkg::BIRTH_RESET;
      frame_w      = clamp_dim(cas_pkg::GRID_WIDTH_RESET, cas_pkg::MIN_WIDTH, MAX_WIDTH);
      frame_h      = clamp_dim(cas_pkg::GRID_HEIGHT_RESET, cas_pkg::MIN_HEIGHT, MAX_HEIGHT);
      stream_pos   = 0;
      tail_flagged = 1'b0;
      expected_cells.delete();
      foreach (hist_cells[i]) hist_cells[i] = 1'b0;
    end else begin
      // register writes
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          cas_pkg::REG_GRID_WIDTH:  width_reg   = cfg_bus.data;
          cas_pkg::REG_GRID_HEIGHT: height_reg  = cfg_bus.data;
          cas_pkg::REG_SURVIVE_MIN: survive_reg = cfg_bus.data[3:0];
          cas_pkg::REG_BIRTH_MIN:   birth_reg   = cfg_bus.data[3:0];
          default: ;
        endcase
      end
      // results against the oldest prediction
      if (out_bus.valid && out_bus.ready) begin
        if (expected_cells.size() == 0) begin
          report_mismatch("result arrived with nothing predicted");
        end else begin
          want = expected_cells.pop_front();
          if (out_bus.next_cell !== want.next_cell) begin
            report_mismatch($sformatf("result %0d next_cell got %b want %b",
                                      results_checked, out_bus.next_cell, want.next_cell));
          end
          if (out_bus.frame_last !== want.frame_last) begin
            report_mismatch($sformatf("result %0d frame_last got %b want %b",
                                      results_checked, out_bus.frame_last, want.frame_last));
          end
          if (want.frame_last) frames_closed++;
        end
        results_checked++;
      end
      // requests
      if (in_bus.valid && in_bus.ready) generation_step(in_bus.mode, in_bus.cell_req);
      if (stream_done && !tail_flagged && expected_cells.size() != 0) begin
        report_mismatch($sformatf("%0d predicted results never arrived",
                                  expected_cells.size()));
        tail_flagged = 1'b1;
      end
    end
    pending_results <= expected_cells.size();
  end

endmodule : cave_step_checker

### verif/tb_cave_automaton_step.sv
// Testbench top for the cave automaton step: clock, reset, request stimulus, stalls, verdict.
module tb_cave_automaton_step;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_MAX_W    = 128;
  localparam int GRID_MAX_H    = 128;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_CELLS  = 180;

  logic        clk;
  logic        rst;
  logic        stream_done;
  bit          calm;
  int unsigned width_now, height_now;
  int unsigned requests_sent, cells_sent;
  int          pending_results, fail_count, results_checked, frames_closed;

  cas_cfg_if cfg_bus();
  cas_in_if  in_bus();
  cas_out_if out_bus();

  cave_automaton_step #(
    .MAX_WIDTH (GRID_MAX_W),
    .MAX_HEIGHT(GRID_MAX_H)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_bus),
    .item  (in_bus),
    .result(out_bus)
  );

  cave_step_checker #(
    .MAX_WIDTH (GRID_MAX_W),
    .MAX_HEIGHT(GRID_MAX_H)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_bus        (cfg_bus),
    .in_bus         (in_bus),
    .out_bus        (out_bus),
    .stream_done    (stream_done),
    .pending_results(pending_results),
    .fail_count     (fail_count),
    .results_checked(results_checked),
    .frames_closed  (frames_closed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no gap, some short ones, a few long ones; none in calm stretches
  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side backpressure
  initial begin : result_stall
    int unsigned hold;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_bus.ready <= 1'b0;
        hold--;
      end else begin
        out_bus.ready <= 1'b1;
        hold = idle_gap();
      end
    end
  end

  // Ends the run when no channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cfg_bus.valid && cfg_bus.ready) || (in_bus.valid && in_bus.ready) ||
          (out_bus.valid && out_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // One request; valid stays high into the next request when there is no gap
  task automatic push_request(logic md, logic cv);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.mode     <= md;
    in_bus.cell_req <= cv;
    do @(posedge clk); while (!in_bus.ready);
    requests_sent++;
    if (md == cas_pkg::MODE_CELL) cells_sent++;
  endtask

  // Hold requests until every predicted result is out, then let the pipe empty
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cas_pkg::cfg_index_t idx, int unsigned val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= cas_pkg::cfg_data_t'(val);
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == cas_pkg::REG_GRID_WIDTH) width_now = val;
    if (idx == cas_pkg::REG_GRID_HEIGHT) height_now = val;
    @(posedge clk);
  endtask

  // A whole frame with stray flushes among the cells and stray cells in the drain
  task automatic send_frame(int unsigned fill_pct, int unsigned noise_pct);
    int unsigned w, h;
    w = (width_now < cas_pkg::MIN_WIDTH) ? cas_pkg::MIN_WIDTH :
        (width_now > GRID_MAX_W) ? GRID_MAX_W : width_now;
    h = (height_now < cas_pkg::MIN_HEIGHT) ? cas_pkg::MIN_HEIGHT :
        (height_now > GRID_MAX_H) ? GRID_MAX_H : height_now;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        push_request(cas_pkg::MODE_FLUSH, 1'($urandom_range(1)));
      end
      push_request(cas_pkg::MODE_CELL, $urandom_range(99) < fill_pct);
    end
    // w+1 drain requests; a cell here acts as a flush
    for (int unsigned i = 0; i <= w; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        push_request(cas_pkg::MODE_CELL, 1'($urandom_range(1)));
      end else begin
        push_request(cas_pkg::MODE_FLUSH, 1'($urandom_range(1)));
      end
    end
  endtask

  // New register values between frames
  task automatic pick_settings();
    int unsigned roll;
    settle();
    if ($urandom_range(99) < 60) begin
      roll = $urandom_range(99);
      write_reg(cas_pkg::REG_GRID_WIDTH, (roll < 8)  ? $urandom_range(0, 2) :
                                         (roll < 85) ? $urandom_range(3, 10) :
                                                       $urandom_range(11, 24));
    end
    if ($urandom_range(99) < 60) begin
      roll = $urandom_range(99);
      write_reg(cas_pkg::REG_GRID_HEIGHT, (roll < 8)  ? 0 :
                                          (roll < 85) ? $urandom_range(1, 6) :
                                                        $urandom_range(7, 10));
    end
    if ($urandom_range(1) != 0) begin
      roll = $urandom_range(99);
      write_reg(cas_pkg::REG_SURVIVE_MIN, (roll < 12) ? $urandom_range(9, 15) :
                                                        $urandom_range(0, 8));
    end
    if ($urandom_range(1) != 0) begin
      roll = $urandom_range(99);
      write_reg(cas_pkg::REG_BIRTH_MIN, (roll < 12) ? $urandom_range(9, 15) :
                                                      $urandom_range(0, 8));
    end
  endtask

  initial begin : stimulus
    int unsigned roll, goal;
    calm          = 1'b0;
    width_now     = cas_pkg::GRID_WIDTH_RESET;
    height_now    = cas_pkg::GRID_HEIGHT_RESET;
    requests_sent = 0;
    cells_sent    = 0;
    rst             <= 1'b1;
    stream_done     <= 1'b0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= cas_pkg::REG_GRID_WIDTH;
    cfg_bus.data    <= '0;
    in_bus.valid    <= 1'b0;
    in_bus.mode     <= cas_pkg::MODE_CELL;
    in_bus.cell_req <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Flush with nothing pending
    push_request(cas_pkg::MODE_FLUSH, 1'b1);

    // Geometry below the floor gives a single-row 3x1 frame, default thresholds;
    // a flush among the cells is dropped, the first drain flush releases nothing
    settle();
    write_reg(cas_pkg::REG_GRID_WIDTH, 0);
    write_reg(cas_pkg::REG_GRID_HEIGHT, 0);
    push_request(cas_pkg::MODE_CELL, 1'b0);
    push_request(cas_pkg::MODE_FLUSH, 1'b0);
    push_request(cas_pkg::MODE_CELL, 1'b1);
    push_request(cas_pkg::MODE_CELL, 1'b0);
    repeat (4) push_request(cas_pkg::MODE_FLUSH, 1'b0);

    // 3x2 with an unreachable survive threshold; geometry rewritten mid-frame
    // must only take effect on the next frame; a cell in the drain acts as flush
    settle();
    write_reg(cas_pkg::REG_SURVIVE_MIN, 9);
    write_reg(cas_pkg::REG_BIRTH_MIN, 8);
    write_reg(cas_pkg::REG_GRID_WIDTH, 3);
    write_reg(cas_pkg::REG_GRID_HEIGHT, 2);
    push_request(cas_pkg::MODE_CELL, 1'b1);
    settle();
    write_reg(cas_pkg::REG_GRID_WIDTH, 5);
    write_reg(cas_pkg::REG_GRID_HEIGHT, 3);
    push_request(cas_pkg::MODE_CELL, 1'b0);
    push_request(cas_pkg::MODE_CELL, 1'b1);
    push_request(cas_pkg::MODE_CELL, 1'b1);
    push_request(cas_pkg::MODE_CELL, 1'b0);
    push_request(cas_pkg::MODE_CELL, 1'b1);
    push_request(cas_pkg::MODE_FLUSH, 1'b1);
    push_request(cas_pkg::MODE_CELL, 1'b0);
    push_request(cas_pkg::MODE_FLUSH, 1'b0);
    push_request(cas_pkg::MODE_FLUSH, 1'b1);

    // Random small frames, back to back or with new settings in between
    goal = cells_sent + RANDOM_CELLS;
    while (cells_sent < goal) begin
      calm = ($urandom_range(3) == 0);
      roll = $urandom_range(99);
      send_frame((roll < 10) ? 0 : (roll < 20) ? 100 : $urandom_range(20, 80),
                 ($urandom_range(99) < 40) ? 0 : $urandom_range(1, 8));
      if ($urandom_range(4) == 0) push_request(cas_pkg::MODE_FLUSH, 1'($urandom_range(1)));
      if ($urandom_range(2) != 0) pick_settings();
    end
    calm = 1'b0;

    // Largest geometry: full height, then a width above the ceiling
    settle();
    write_reg(cas_pkg::REG_SURVIVE_MIN, $urandom_range(3, 6));
    write_reg(cas_pkg::REG_BIRTH_MIN, $urandom_range(3, 6));
    write_reg(cas_pkg::REG_GRID_WIDTH, 2);
    write_reg(cas_pkg::REG_GRID_HEIGHT, 128);
    send_frame(45, 2);
    settle();
    write_reg(cas_pkg::REG_GRID_WIDTH, 255);
    write_reg(cas_pkg::REG_GRID_HEIGHT, 1);
    write_reg(cas_pkg::REG_SURVIVE_MIN, 8);
    write_reg(cas_pkg::REG_BIRTH_MIN, 8);
    send_frame(90, 2);

    // Drain and verdict
    settle();
    stream_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Sent %0d requests (%0d cells); %0d results compared over %0d frames.",
             requests_sent, cells_sent, results_checked, frames_closed);
    $display("Grids from 3x1 to 128 columns and 128 rows, thresholds 0..15, clamped geometry.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule : tb_cave_automaton_step
